[rtl/core/metric_slots_with_log2_histogram_macros.svh]
// assertion macros shared by the metric slot block
`ifndef METRIC_SLOTS_WITH_LOG2_HISTOGRAM_MACROS_SVH
`define METRIC_SLOTS_WITH_LOG2_HISTOGRAM_MACROS_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define MSLH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off while arst_n is low
`define MSLH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mslh_pkg.sv]
// types, codes and constants of the metric slot block
package mslh_pkg;

	// default sizes
	localparam int SLOTS_DEF   = 16;
	localparam int BUCKETS_DEF = 32;
	localparam int QUEUE_DEPTH = 2;

	// field widths
	localparam int MODE_W    = 3;
	localparam int SLOT_W    = 4;
	localparam int AMT_W     = 64;
	localparam int DUR_W     = 48;
	localparam int PCT_W     = 14;
	localparam int STAT_W    = 2;
	localparam int BKT_OUT_W = 5;
	localparam int CNT_W     = 64;

	// operation codes of the mode field
	localparam logic [MODE_W-1:0] MODE_INC = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEC = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SET = 3'd2;
	localparam logic [MODE_W-1:0] MODE_OBS = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QRY = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STAT_W-1:0] ST_NODATA = 2'd2;

	// duration is Q40.8 microseconds
	localparam int               FRAC_BITS  = 8;
	localparam logic [DUR_W-1:0] DUR_ONE_US = 48'd256;

	// percentile search: samples times percent against scaled running sums
	localparam int PCT_SCALE = 10000;
	localparam int PROD_W    = 80;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_COUNTER,
		KIND_GAUGE,
		KIND_HIST
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RANGE,
		OP_REJECT,
		OP_NODATA,
		OP_ADD,
		OP_SUB,
		OP_SET,
		OP_OBSERVE,
		OP_QUERY
	} op_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_OBS,
		B_MUL,
		B_SCAN
	} bstate_t;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [SLOT_W-1:0]       slot;
		logic signed [AMT_W-1:0] amount;
		logic [DUR_W-1:0]        duration;
		logic [PCT_W-1:0]        percent;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [AMT_W-1:0] metric_value;
		logic [BKT_OUT_W-1:0]    bucket_index;
		logic [CNT_W-1:0]        sample_count;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t                     op;
		logic [SLOT_W-1:0]       slot;
		logic signed [AMT_W-1:0] amount;
		logic [DUR_W-1:0]        duration;
		logic [PCT_W-1:0]        percent;
	} job_t;

endpackage

[rtl/core/mslh_stream_if.sv]
// valid/ready stream channel carrying one payload per beat
interface mslh_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/mslh_ram.sv]
// generic single-write single-read ram with registered read data
module mslh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/mslh_front.sv]
// front end: accepts items, checks slot kinds, claims slots, queues jobs
module mslh_front #(
	parameter int SLOTS = mslh_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	mslh_stream_if.sink      item,
	input  logic             hold,
	input  logic             q_full,
	output logic             push,
	output mslh_pkg::job_t   job
);

	localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	mslh_pkg::kind_t   kind_q [SLOTS];
	mslh_pkg::kind_t   kind_cur;
	mslh_pkg::kind_t   want;
	mslh_pkg::op_t     upd_op;
	mslh_pkg::op_t     op;
	logic [SIDX_W-1:0] sidx;
	logic              in_range;
	logic              mode_ok;
	logic              claim;

	assign item.ready = !q_full && !hold;
	assign push       = item.valid && item.ready;
	assign sidx       = SIDX_W'(item.payload.slot);
	assign in_range   = 32'(item.payload.slot) < 32'(SLOTS);
	assign kind_cur   = kind_q[sidx];

	always_comb begin
		want    = mslh_pkg::KIND_NONE;
		upd_op  = mslh_pkg::OP_NONE;
		mode_ok = 1'b1;
		unique case (item.payload.mode)
			mslh_pkg::MODE_INC: begin
				want   = mslh_pkg::KIND_COUNTER;
				upd_op = mslh_pkg::OP_ADD;
			end
			mslh_pkg::MODE_DEC: begin
				want   = mslh_pkg::KIND_COUNTER;
				upd_op = mslh_pkg::OP_SUB;
			end
			mslh_pkg::MODE_SET: begin
				want   = mslh_pkg::KIND_GAUGE;
				upd_op = mslh_pkg::OP_SET;
			end
			mslh_pkg::MODE_OBS: begin
				want   = mslh_pkg::KIND_HIST;
				upd_op = mslh_pkg::OP_OBSERVE;
			end
			mslh_pkg::MODE_QRY: begin
				want   = mslh_pkg::KIND_HIST;
				upd_op = mslh_pkg::OP_QUERY;
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase

		claim = 1'b0;
		if (!mode_ok) begin
			op = mslh_pkg::OP_NONE;
		end else if (!in_range) begin
			op = mslh_pkg::OP_RANGE;
		end else if (upd_op == mslh_pkg::OP_QUERY) begin
			// a query never claims
			op = (kind_cur == mslh_pkg::KIND_HIST) ? mslh_pkg::OP_QUERY : mslh_pkg::OP_NODATA;
		end else if (kind_cur == mslh_pkg::KIND_NONE) begin
			op    = upd_op;
			claim = 1'b1;
		end else if (kind_cur == want) begin
			op = upd_op;
		end else begin
			op = mslh_pkg::OP_REJECT;
		end
	end

	always_comb begin
		job.op       = op;
		job.slot     = item.payload.slot;
		job.amount   = item.payload.amount;
		job.duration = item.payload.duration;
		job.percent  = item.payload.percent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				kind_q[i] <= mslh_pkg::KIND_NONE;
			end
		end else if (push && claim) begin
			kind_q[sidx] <= want;
		end
	end

endmodule

[rtl/core/mslh_fifo.sv]
// short job queue between front and back
module mslh_fifo #(
	parameter int DEPTH = mslh_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mslh_pkg::job_t wdata,
	output logic           full,
	input  logic           pop,
	output mslh_pkg::job_t rdata,
	output logic           empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	mslh_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/mslh_back.sv]
// back end: slot values, sample counts, bucket ram, percentile search
module mslh_back #(
	parameter int SLOTS   = mslh_pkg::SLOTS_DEF,
	parameter int BUCKETS = mslh_pkg::BUCKETS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mslh_pkg::job_t head,
	input  logic           head_vld,
	output logic           pop,
	output logic           clearing,
	mslh_stream_if.source  result
);

	localparam int SIDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BIDX_W    = $clog2(BUCKETS);
	localparam int MEM_DEPTH = SLOTS * BUCKETS;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int BO_W      = mslh_pkg::BKT_OUT_W;
	localparam int CW        = mslh_pkg::CNT_W;
	localparam int PW        = mslh_pkg::PROD_W;
	localparam int BLW       = 6;
	localparam logic [PW-1:0]     SCALE    = PW'(mslh_pkg::PCT_SCALE);
	localparam logic [BIDX_W-1:0] LAST_BKT = BIDX_W'(BUCKETS - 1);
	localparam logic [AW-1:0]     LAST_ADR = AW'(MEM_DEPTH - 1);
	localparam logic [AW-1:0]     ROW_LEN  = AW'(BUCKETS);

	mslh_pkg::bstate_t state_q, state_d;

	logic [CW-1:0] value_q   [SLOTS];
	logic [CW-1:0] samples_q [SLOTS];

	logic [SIDX_W-1:0] hidx, sidx_q;
	logic [BIDX_W-1:0] head_bkt, bkt_q;
	logic [AW-1:0]     head_addr, addr_q, base_q, clr_addr_q;
	logic [mslh_pkg::PCT_W-1:0] pct_q;
	logic [CW-1:0]     hval, hsmp, cval, csmp;

	// ram port
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [CW-1:0] ram_wdata, ram_rdata;

	// percentile datapath
	logic [PW-1:0]     prod_q;
	logic [CW-1:0]     cum_q, cum_new;
	logic [BIDX_W-1:0] iss_idx_q, chk_idx_q, cmp_idx_q;
	logic              iss_on_q, chk_on_q, cmp_on_q;
	logic              cmp_hit;

	// control strobes
	logic              val_we, smp_we, load_res, res_free;
	logic [CW-1:0]     val_new, smp_new;
	mslh_pkg::result_t res_d, out_q;
	logic              out_valid_q;

	function automatic logic [BIDX_W-1:0] bucket_of(input logic [mslh_pkg::DUR_W-1:0] d);
		logic [mslh_pkg::DUR_W-1:0] dm;
		logic [BLW-1:0]             bl;
		logic [BLW-1:0]             b;
		dm = d - 1'b1;
		bl = '0;
		for (int i = 0; i < mslh_pkg::DUR_W; i++) begin
			if (dm[i]) begin
				bl = BLW'(i + 1);
			end
		end
		b = bl - BLW'(mslh_pkg::FRAC_BITS);
		if (d <= mslh_pkg::DUR_ONE_US) begin
			return '0;
		end
		if (32'(b) >= BUCKETS) begin
			return LAST_BKT;
		end
		return BIDX_W'(b);
	endfunction

	assign hidx      = SIDX_W'(head.slot);
	assign head_bkt  = bucket_of(head.duration);
	assign head_addr = AW'(hidx) * ROW_LEN + AW'(head_bkt);
	assign hval      = value_q[hidx];
	assign hsmp      = samples_q[hidx];
	assign cval      = value_q[sidx_q];
	assign csmp      = samples_q[sidx_q];
	assign cum_new   = cum_q + ram_rdata;
	assign res_free  = !out_valid_q || result.ready;
	assign clearing  = (state_q == mslh_pkg::B_CLEAR);

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	mslh_ram #(
		.WIDTH(CW),
		.DEPTH(MEM_DEPTH)
	) u_bkt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// running sum reaches floor(prod / 10000), at least 1, saturated at all ones,
	// exactly when (sum + 1) * 10000 > prod; 10000 = 8192 + 1024 + 512 + 256 + 16
	always_comb begin
		logic [PW-1:0] c1;
		logic [PW-1:0] scaled;
		c1      = PW'(cum_q) + PW'(1);
		scaled  = (c1 << 13) + (c1 << 10) + (c1 << 9) + (c1 << 8) + (c1 << 4);
		cmp_hit = ((cum_q != '0) || (prod_q >= SCALE)) && ((scaled > prod_q) || (cum_q == '1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mslh_pkg::B_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = head_addr;
		val_we    = 1'b0;
		val_new   = '0;
		smp_we    = 1'b0;
		smp_new   = '0;
		load_res  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			mslh_pkg::B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				if (clr_addr_q == LAST_ADR) begin
					state_d = mslh_pkg::B_IDLE;
				end
			end
			mslh_pkg::B_IDLE: begin
				if (head_vld && res_free) begin
					pop = 1'b1;
					unique case (head.op) inside
						mslh_pkg::OP_NONE: begin
							load_res = 1'b1;
						end
						mslh_pkg::OP_RANGE: begin
							load_res     = 1'b1;
							res_d.status = mslh_pkg::ST_REJECT;
						end
						mslh_pkg::OP_REJECT: begin
							load_res           = 1'b1;
							res_d.status       = mslh_pkg::ST_REJECT;
							res_d.metric_value = hval;
							res_d.sample_count = hsmp;
						end
						mslh_pkg::OP_NODATA: begin
							load_res           = 1'b1;
							res_d.status       = mslh_pkg::ST_NODATA;
							res_d.metric_value = hval;
							res_d.sample_count = hsmp;
						end
						mslh_pkg::OP_ADD, mslh_pkg::OP_SUB, mslh_pkg::OP_SET: begin
							if (head.op == mslh_pkg::OP_ADD) begin
								val_new = hval + head.amount;
							end else if (head.op == mslh_pkg::OP_SUB) begin
								val_new = hval - head.amount;
							end else begin
								val_new = head.amount;
							end
							val_we             = 1'b1;
							load_res           = 1'b1;
							res_d.status       = mslh_pkg::ST_OK;
							res_d.metric_value = val_new;
							res_d.sample_count = hsmp;
						end
						mslh_pkg::OP_OBSERVE: begin
							state_d = mslh_pkg::B_OBS;
						end
						mslh_pkg::OP_QUERY: begin
							if (hsmp == '0) begin
								load_res           = 1'b1;
								res_d.status       = mslh_pkg::ST_NODATA;
								res_d.metric_value = hval;
							end else begin
								state_d = mslh_pkg::B_MUL;
							end
						end
						default: begin
							load_res = 1'b1;
						end
					endcase
				end
			end
			mslh_pkg::B_OBS: begin
				ram_we             = 1'b1;
				ram_waddr          = addr_q;
				ram_wdata          = ram_rdata + 1'b1;
				smp_we             = 1'b1;
				smp_new            = csmp + 1'b1;
				load_res           = 1'b1;
				res_d.status       = mslh_pkg::ST_OK;
				res_d.metric_value = cval;
				res_d.bucket_index = BO_W'(bkt_q);
				res_d.sample_count = smp_new;
				state_d            = mslh_pkg::B_IDLE;
			end
			mslh_pkg::B_MUL: begin
				state_d = mslh_pkg::B_SCAN;
			end
			mslh_pkg::B_SCAN: begin
				ram_raddr = base_q + AW'(iss_idx_q);
				if (cmp_on_q && (cmp_hit || cmp_idx_q == LAST_BKT)) begin
					load_res           = 1'b1;
					res_d.status       = mslh_pkg::ST_OK;
					res_d.metric_value = cval;
					res_d.bucket_index = BO_W'(cmp_idx_q);
					res_d.sample_count = csmp;
					state_d            = mslh_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = mslh_pkg::B_IDLE;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			iss_on_q    <= 1'b0;
			chk_on_q    <= 1'b0;
			cmp_on_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				value_q[i]   <= '0;
				samples_q[i] <= '0;
			end
		end else begin
			if (clearing) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (val_we) begin
				value_q[hidx] <= val_new;
			end
			if (smp_we) begin
				samples_q[sidx_q] <= smp_new;
			end
			if (state_q == mslh_pkg::B_MUL) begin
				iss_on_q <= 1'b1;
				chk_on_q <= 1'b0;
				cmp_on_q <= 1'b0;
			end else if (state_q == mslh_pkg::B_SCAN) begin
				chk_on_q <= iss_on_q;
				cmp_on_q <= chk_on_q;
				if (iss_on_q && iss_idx_q == LAST_BKT) begin
					iss_on_q <= 1'b0;
				end
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			sidx_q <= hidx;
			addr_q <= head_addr;
			bkt_q  <= head_bkt;
			pct_q  <= head.percent;
		end
		if (state_q == mslh_pkg::B_MUL) begin
			prod_q    <= PW'(csmp) * PW'(pct_q);
			base_q    <= AW'(sidx_q) * ROW_LEN;
			cum_q     <= '0;
			iss_idx_q <= '0;
		end
		if (state_q == mslh_pkg::B_SCAN) begin
			chk_idx_q <= iss_idx_q;
			cmp_idx_q <= chk_idx_q;
			if (iss_on_q && iss_idx_q != LAST_BKT) begin
				iss_idx_q <= iss_idx_q + 1'b1;
			end
			if (chk_on_q) begin
				cum_q <= cum_new;
			end
		end
		if (load_res) begin
			out_q <= res_d;
		end
	end

endmodule

[rtl/core/metric_slots_with_log2_histogram.sv]
// top level of the metric slot table with log2 latency histograms
`include "metric_slots_with_log2_histogram_macros.svh"

// Metric slot table: SLOTS slots addressed by index, each claimed on first
// update as a counter, a gauge or a log2 histogram of BUCKETS buckets; a later
// update of another kind is rejected and leaves the slot alone. Every item
// gives exactly one result beat, in order. The front checks and claims slot
// kinds and accepts one item per cycle into a two-entry job queue while the
// queue has room and no ram sweep runs; the back executes one job at a time.
// An observe is a read-modify-write of the bucket ram (one registered read
// port, one write port). A percentile query on a histogram with samples goes
// through pop, one 64x14 multiply of samples by percent, then a scan of the
// slot's bucket row at one ram read per cycle with a running 64-bit sum; each
// sum plus one is scaled by 10000 with shifts and adds and compared with the
// product in the cycle after its bucket arrives, so no division is needed.
// After reset the back sweeps all SLOTS*BUCKETS words of the bucket ram to
// zero (512 at the defaults); item.ready stays low during the sweep. A
// finished result waits in an output register, so the front keeps taking
// items while the sink stalls, until the queue fills.
module metric_slots_with_log2_histogram #(
	parameter int SLOTS   = mslh_pkg::SLOTS_DEF,
	parameter int BUCKETS = mslh_pkg::BUCKETS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mslh_stream_if.sink   item,
	mslh_stream_if.source result
);

	// front to queue
	logic           push;
	mslh_pkg::job_t job_in;
	logic           q_full;

	// queue to back
	logic           pop;
	mslh_pkg::job_t job_head;
	logic           q_empty;

	// back holds the front off while the bucket ram is swept
	logic           clearing;

	// result beat flags for the checks below
	logic           res_nodata;
	logic           res_clean;

	mslh_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.hold  (clearing),
		.q_full(q_full),
		.push  (push),
		.job   (job_in)
	);

	mslh_fifo #(
		.DEPTH(mslh_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_in),
		.full  (q_full),
		.pop   (pop),
		.rdata (job_head),
		.empty (q_empty)
	);

	mslh_back #(
		.SLOTS  (SLOTS),
		.BUCKETS(BUCKETS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (job_head),
		.head_vld(!q_empty),
		.pop     (pop),
		.clearing(clearing),
		.result  (result)
	);

	assign res_nodata = result.valid && result.payload.status == mslh_pkg::ST_NODATA;
	assign res_clean  = result.payload.bucket_index == '0 && result.payload.sample_count == '0;

	// no item gets in while the bucket ram is being swept
	`MSLH_ASSERT_IMP(a_hold_in_clear, clearing, !item.ready, "item ready during ram sweep")

	// an accepted beat is in the queue in the next cycle
	`MSLH_ASSERT_NXT(a_push_lands, item.valid && item.ready, !q_empty, "accepted item lost")

	// nothing can be queued before the sweep ends
	`MSLH_ASSERT_IMP(a_clear_exit, $fell(clearing), q_empty, "queue not empty after sweep")

	// no-data answers carry neither a bucket nor samples
	`MSLH_ASSERT_IMP(a_nodata_clean, res_nodata, res_clean, "no-data result with data")

endmodule

[verif/tb_metric_slots_with_log2_histogram.sv]
// testbench of the metric slot table with log2 histograms: directed table, random beats, predictor
module tb_metric_slots_with_log2_histogram;
	timeunit 1ns;
	timeprecision 1ps;

	import mslh_pkg::*;

	// sizes of the block as built
	localparam int NSLOT = SLOTS_DEF;
	localparam int NBKT  = BUCKETS_DEF;

	// the worst legal run stays far below this
	localparam int CYCLE_LIMIT = 400000;
	// quiet cycles after the last result, longer than a full query
	localparam int TAIL_CYCLES = 80;
	// random beats per idle phase
	localparam int PHASE_BEATS = 167;
	// mismatch lines printed before going quiet
	localparam int REPORT_CAP  = 40;

	// modes the block ignores
	localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	// amount extremes
	localparam logic [AMT_W-1:0] A_MAX  = 64'h7fff_ffff_ffff_ffff;
	localparam logic [AMT_W-1:0] A_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [AMT_W-1:0] A_ONES = '1;

	// one stimulus row: the beat, and the result when it is typed in
	typedef struct {
		item_t   beat;
		bit      typed;
		result_t want;
	} row_t;

	logic clk;
	logic arst_n;

	mslh_stream_if #(.T(item_t))   item_ch ();
	mslh_stream_if #(.T(result_t)) result_ch ();

	metric_slots_with_log2_histogram DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// predicted contents of the slot table
	kind_t            slot_kind    [NSLOT] = '{default: KIND_NONE};
	logic [AMT_W-1:0] slot_val     [NSLOT] = '{default: '0};
	logic [CNT_W-1:0] hist_samples [NSLOT] = '{default: '0};
	logic [CNT_W-1:0] bkt_cnt      [NSLOT][NBKT];

	// beats handed to the driver, in order, and results still owed by the block
	row_t    launched [$];
	result_t owed_results [$];
	row_t    script [$];

	int errors         = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int results_seen   = 0;
	int mode_seen [8]  = '{default: 0};

	always #1ns clk = ~clk;

	// helpers to build table rows
	function automatic item_t mk(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
			input logic [AMT_W-1:0] a, input logic [DUR_W-1:0] d, input logic [PCT_W-1:0] p);
		item_t it;
		it.mode     = m;
		it.slot     = s;
		it.amount   = a;
		it.duration = d;
		it.percent  = p;
		return it;
	endfunction

	function automatic result_t rs(input logic [STAT_W-1:0] st, input logic [AMT_W-1:0] v,
			input logic [BKT_OUT_W-1:0] b, input logic [CNT_W-1:0] c);
		result_t r;
		r.status       = st;
		r.metric_value = v;
		r.bucket_index = b;
		r.sample_count = c;
		return r;
	endfunction

	function automatic row_t row(input item_t b, input bit typed, input result_t w);
		row_t r;
		r.beat  = b;
		r.typed = typed;
		r.want  = w;
		return r;
	endfunction

	// ceil(log2(us)) of a Q40.8 duration, clamped to the last bucket
	function automatic logic [BKT_OUT_W-1:0] log2_bucket(input logic [DUR_W-1:0] d);
		logic [DUR_W-1:0] m;
		int len;
		if (d <= DUR_ONE_US)
			return '0;
		m = d - 1'b1;
		len = 0;
		for (int i = 0; i < DUR_W; i++)
			if (m[i])
				len = i + 1;
		len = len - FRAC_BITS;
		if (len > NBKT - 1)
			len = NBKT - 1;
		return len[BKT_OUT_W-1:0];
	endfunction

	// first use claims the slot, later uses must match its kind
	function automatic bit claim_slot(input logic [SLOT_W-1:0] s, input kind_t k);
		if (slot_kind[s] == KIND_NONE) begin
			slot_kind[s] = k;
			return 1'b1;
		end
		return slot_kind[s] == k;
	endfunction

	// applies one beat to the predicted table and returns the result it owes
	function automatic result_t apply_update(input item_t it);
		result_t          r;
		logic [SLOT_W-1:0] s;
		logic [BKT_OUT_W-1:0] b;
		logic [79:0]      prod;
		logic [79:0]      quot;
		logic [CNT_W-1:0] goal;
		logic [CNT_W-1:0] run;
		bit               hit;
		r = '0;
		s = it.slot;
		b = '0;
		if (it.mode > MODE_QRY)
			return r;
		case (it.mode)
			MODE_INC, MODE_DEC: begin
				if (!claim_slot(s, KIND_COUNTER))
					r.status = ST_REJECT;
				else if (it.mode == MODE_INC)
					slot_val[s] = slot_val[s] + it.amount;
				else
					slot_val[s] = slot_val[s] - it.amount;
			end
			MODE_SET: begin
				if (!claim_slot(s, KIND_GAUGE))
					r.status = ST_REJECT;
				else
					slot_val[s] = it.amount;
			end
			MODE_OBS: begin
				if (!claim_slot(s, KIND_HIST)) begin
					r.status = ST_REJECT;
				end else begin
					b = log2_bucket(it.duration);
					bkt_cnt[s][b] = bkt_cnt[s][b] + 1'b1;
					hist_samples[s] = hist_samples[s] + 1'b1;
				end
			end
			default: begin
				// percentile query, never claims
				if (slot_kind[s] != KIND_HIST || hist_samples[s] == '0) begin
					r.status = ST_NODATA;
				end else begin
					prod = {16'd0, hist_samples[s]} * {66'd0, it.percent};
					quot = prod / 80'(PCT_SCALE);
					goal = (quot > {16'd0, {CNT_W{1'b1}}}) ? '1 : quot[CNT_W-1:0];
					if (goal == '0)
						goal = 1;
					b = BKT_OUT_W'(NBKT - 1);
					run = '0;
					hit = 1'b0;
					for (int i = 0; i < NBKT; i++)
						if (!hit) begin
							run = run + bkt_cnt[s][i];
							if (run >= goal) begin
								b = BKT_OUT_W'(i);
								hit = 1'b1;
							end
						end
				end
			end
		endcase
		r.metric_value = slot_val[s];
		r.bucket_index = b;
		r.sample_count = hist_samples[s];
		return r;
	endfunction

	task automatic flag_field(input string name, input logic [AMT_W-1:0] want,
			input logic [AMT_W-1:0] got);
		errors++;
		if (errors <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
	endtask

	// random beat, biased toward uses that fit the slot's kind
	function automatic item_t pick_item();
		item_t it;
		int    r;
		int    k;
		logic [63:0] raw;
		it.slot = SLOT_W'($urandom_range(NSLOT - 1));
		r = $urandom_range(99);
		if (r < 4) begin
			it.mode = MODE_W'($urandom_range(7, 5));
		end else if (r < 14) begin
			it.mode = MODE_W'($urandom_range(4));
		end else begin
			case (slot_kind[it.slot])
				KIND_NONE:
					it.mode = ($urandom_range(99) < 55) ? MODE_OBS
						: MODE_W'($urandom_range(2));
				KIND_COUNTER:
					it.mode = $urandom_range(1) ? MODE_INC : MODE_DEC;
				KIND_GAUGE:
					it.mode = ($urandom_range(99) < 85) ? MODE_SET : MODE_QRY;
				default:
					it.mode = ($urandom_range(99) < 62) ? MODE_OBS : MODE_QRY;
			endcase
		end
		// amount: mostly full random bits, sometimes the extremes
		case ($urandom_range(19))
			0: it.amount = A_MAX;
			1: it.amount = A_MIN;
			2: it.amount = A_ONES;
			3: it.amount = 64'($urandom_range(9));
			default: it.amount = {$urandom, $urandom};
		endcase
		// duration: random bit length so every bucket is reached, or a bucket edge
		raw = {$urandom, $urandom};
		if ($urandom_range(99) < 15) begin
			it.duration = (DUR_W'(256) << $urandom_range(39)) + DUR_W'($urandom_range(2)) - 1'b1;
		end else begin
			k = $urandom_range(DUR_W);
			it.duration = (k == 0) ? '0 : DUR_W'(raw[DUR_W-1:0] >> (DUR_W - k));
		end
		// percent: mostly in range, some ends, some above full scale
		r = $urandom_range(99);
		if (r < 5)
			it.percent = '0;
		else if (r < 10)
			it.percent = PCT_W'(PCT_SCALE);
		else if (r < 17)
			it.percent = PCT_W'($urandom_range(16383, PCT_SCALE + 1));
		else
			it.percent = PCT_W'($urandom_range(PCT_SCALE));
		return it;
	endfunction

	// one beat on the item channel; valid only drops when a gap is taken
	task automatic drive_beat(input row_t r);
		launched.push_back(r);
		if ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= r.beat;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// receiver back-pressure
	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run stopped at the cycle limit, %0d results still owed",
				$time, owed_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	// watch both channels: check result beats, predict accepted item beats
	always @(posedge clk) begin : watch
		result_t want;
		result_t got;
		row_t    sent;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			results_seen++;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, actual %h", $time, got);
			end else begin
				want = owed_results.pop_front();
				if (got.status !== want.status)
					flag_field("status", want.status, got.status);
				if (got.metric_value !== want.metric_value)
					flag_field("metric_value", want.metric_value, got.metric_value);
				if (got.bucket_index !== want.bucket_index)
					flag_field("bucket_index", want.bucket_index, got.bucket_index);
				if (got.sample_count !== want.sample_count)
					flag_field("sample_count", want.sample_count, got.sample_count);
			end
		end
		if (arst_n && item_ch.valid && item_ch.ready) begin
			sent = launched.pop_front();
			mode_seen[item_ch.payload.mode]++;
			want = apply_update(item_ch.payload);
			// typed rows carry their own answer, the predictor still tracks state
			owed_results.push_back(sent.typed ? sent.want : want);
		end
	end

	initial begin
		item_t it;
		int    n;
		bit    paused;

		for (int s = 0; s < NSLOT; s++)
			for (int b = 0; b < NBKT; b++)
				bkt_cnt[s][b] = '0;

		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;

		// directed table
		// empty table answers no data
		script.push_back(row(mk(MODE_QRY, 0, 0, 0, 0), 1, rs(ST_NODATA, 0, 0, 0)));
		// counter wraps both ways
		script.push_back(row(mk(MODE_INC, 0, A_MAX, 0, 0), 1, rs(ST_OK, A_MAX, 0, 0)));
		script.push_back(row(mk(MODE_INC, 0, 1, 0, 0), 1, rs(ST_OK, A_MIN, 0, 0)));
		script.push_back(row(mk(MODE_DEC, 0, A_MIN, 0, 0), 1, rs(ST_OK, 0, 0, 0)));
		script.push_back(row(mk(MODE_DEC, 0, 1, 0, 0), 1, rs(ST_OK, A_ONES, 0, 0)));
		// wrong kinds on a counter
		script.push_back(row(mk(MODE_SET, 0, 5, 0, 0), 1, rs(ST_REJECT, A_ONES, 0, 0)));
		script.push_back(row(mk(MODE_OBS, 0, 0, 1000, 0), 1,
			rs(ST_REJECT, A_ONES, 0, 0)));
		script.push_back(row(mk(MODE_QRY, 0, 0, 0, 5000), 1,
			rs(ST_NODATA, A_ONES, 0, 0)));
		// gauge takes both extremes, refuses a counter step
		script.push_back(row(mk(MODE_SET, 1, A_MIN, 0, 0), 1, rs(ST_OK, A_MIN, 0, 0)));
		script.push_back(row(mk(MODE_SET, 1, A_MAX, 0, 0), 1, rs(ST_OK, A_MAX, 0, 0)));
		script.push_back(row(mk(MODE_INC, 1, 3, 0, 0), 1, rs(ST_REJECT, A_MAX, 0, 0)));
		script.push_back(row(mk(MODE_QRY, 1, 0, 0, 9000), 1,
			rs(ST_NODATA, A_MAX, 0, 0)));
		// histogram bucket edges around 1 us and 2 us, the clamp at the top
		script.push_back(row(mk(MODE_OBS, 2, 0, 0, 0), 1, rs(ST_OK, 0, 0, 1)));
		script.push_back(row(mk(MODE_OBS, 2, 0, 256, 0), 1, rs(ST_OK, 0, 0, 2)));
		script.push_back(row(mk(MODE_OBS, 2, 0, 257, 0), 1, rs(ST_OK, 0, 1, 3)));
		script.push_back(row(mk(MODE_OBS, 2, 0, 512, 0), 0, '0));
		script.push_back(row(mk(MODE_OBS, 2, 0, 513, 0), 0, '0));
		script.push_back(row(mk(MODE_OBS, 2, 0, '1, 0), 1, rs(ST_OK, 0, 31, 6)));
		script.push_back(row(mk(MODE_OBS, 2, 0, 48'd256 << 30, 0), 0, '0));
		// queries: zero target, full scale, above full scale, median
		script.push_back(row(mk(MODE_QRY, 2, 0, 0, 0), 0, '0));
		script.push_back(row(mk(MODE_QRY, 2, 0, 0, 14'd10000), 0, '0));
		script.push_back(row(mk(MODE_QRY, 2, 0, 0, '1), 0, '0));
		script.push_back(row(mk(MODE_QRY, 2, 0, 0, 14'd5000), 0, '0));
		script.push_back(row(mk(MODE_INC, 2, 7, 0, 0), 1, rs(ST_REJECT, 0, 0, 7)));
		// ignored modes leave slots unclaimed
		script.push_back(row(mk(MODE_SPARE5, 3, A_MAX, '1, '1), 1, '0));
		script.push_back(row(mk(MODE_SPARE6, 15, 1, 1, 1), 1, '0));
		script.push_back(row(mk(MODE_SPARE7, 15, A_ONES, '1, '1), 1, '0));
		script.push_back(row(mk(MODE_QRY, 15, 0, 0, '1), 1, rs(ST_NODATA, 0, 0, 0)));
		script.push_back(row(mk(MODE_DEC, 3, A_MAX, 0, 0), 0, '0));

		// reset held, then released away from the active edge
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 32;
		recv_idle_pct = 45;
		foreach (script[i])
			drive_beat(script[i]);

		// three idle phases: receiver-heavy gaps, sender-heavy gaps, none
		paused = 1'b0;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 45 : 0;
			recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 32 : 0;
			n = 0;
			while (n < PHASE_BEATS) begin
				it = pick_item();
				drive_beat(row(it, 0, '0));
				if (it.mode <= MODE_QRY)
					n++;
				// once, hold the sender until the block has drained
				if (phase == 0 && n == 80 && !paused) begin
					paused = 1'b1;
					item_ch.valid <= 1'b0;
					do @(posedge clk); while (owed_results.size() != 0);
				end
			end
		end

		// drain, then watch for stray beats
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d item beats (inc %0d, dec %0d, set %0d, observe %0d, query %0d)",
			mode_seen[0] + mode_seen[1] + mode_seen[2] + mode_seen[3] + mode_seen[4]
				+ mode_seen[5] + mode_seen[6] + mode_seen[7],
			mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4]);
		$display("ignored-mode beats %0d, result beats checked %0d, mismatches %0d",
			mode_seen[5] + mode_seen[6] + mode_seen[7], results_seen, errors);
		if (errors == 0 && owed_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
